### hdl/sha_pkg.sv
// Shared types, constants and codes of the segment hole allocator.
package sha_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int ADDR_W      = 20;
   localparam int SIZE_W      = ADDR_W + 1;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int CSR_W       = 2;
   // index of the second look-ahead cell (falls back to the head on a two-entry row)
   localparam int LOOK2       = (MAX_ENTRIES > 2) ? 2 : 0;

   localparam logic [SIZE_W-1:0] MEM_LIMIT  = SIZE_W'(1) << ADDR_W;
   localparam logic [SIZE_W-1:0] MEM_RESET  = SIZE_W'(1048576);
   localparam logic [SIZE_W-1:0] SEG0_RESET = SIZE_W'(128);

   typedef enum logic [1:0] {
      CMD_INIT  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_FREE  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_COMPACT   = 3'd1,
      ST_NO_SPACE  = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2,
      FIT_ALT   = 2'd3
   } fit_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_FIT  = 2'd0,
      CSR_MEM  = 2'd1,
      CSR_SEG0 = 2'd2,
      CSR_NONE = 2'd3
   } csr_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SCAN,
      PH_DECIDE,
      PH_APPLY,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] size;
      logic              free;
   } entry_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [SIZE_W-1:0] alloc_size;
      logic [ADDR_W-1:0] segment_base;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] granted_base;
      logic [SIZE_W-1:0] free_total;
      logic [CNT_W-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      fit_type           fit_policy;
      logic [SIZE_W-1:0] memory_size;
      logic [SIZE_W-1:0] segment_zero_size;
   } cfg_type;

endpackage

### hdl/segment_hole_allocator.sv
// Top level: register file, ring of table cells and the sequencer.
// Steps from start to result: an init runs a rewrite rotation; a successful allocate or free
// runs a scan rotation, a decision step and a rewrite rotation; a refused allocate or free runs
// a scan rotation and a decision step; an unknown command goes straight to the result.
// One word at a time; busy stays high until the result strobe. The receiver cannot stall.
// Reset (synchronous) loads the register defaults and runs a silent init pass, with busy
// high, before the first word is taken.
module segment_hole_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  sha_pkg::req_type              req_word,
   output logic                          rsp_valid,
   output sha_pkg::rsp_type              rsp_word,
   input  logic                          csr_we,
   input  logic [sha_pkg::CSR_W-1:0]     csr_index,
   input  logic [sha_pkg::SIZE_W-1:0]    csr_wdata
);

   sha_pkg::cfg_type   cfg_ff;
   sha_pkg::entry_type cells [sha_pkg::MAX_ENTRIES];
   sha_pkg::entry_type tail_word;
   logic               shift_en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fit_policy        <= sha_pkg::FIT_FIRST;
         cfg_ff.memory_size       <= sha_pkg::MEM_RESET;
         cfg_ff.segment_zero_size <= sha_pkg::SEG0_RESET;
      end else if (csr_we) begin
         case (sha_pkg::csr_type'(csr_index))
            sha_pkg::CSR_FIT:  cfg_ff.fit_policy <= sha_pkg::fit_type'(csr_wdata[1:0]);
            sha_pkg::CSR_MEM:  cfg_ff.memory_size <= csr_wdata;
            sha_pkg::CSR_SEG0: cfg_ff.segment_zero_size <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ring of cells; cell 0 is the head, the last cell takes the streamed word
   for (genvar i = 0; i < sha_pkg::MAX_ENTRIES; i++) begin : g_cell
      if (i == sha_pkg::MAX_ENTRIES - 1) begin : g_tail
         sha_cell u_cell (
            .clock     (clock),
            .shift_en  (shift_en),
            .nbr_in    (tail_word),
            .entry_out (cells[i])
         );
      end else begin : g_body
         sha_cell u_cell (
            .clock     (clock),
            .shift_en  (shift_en),
            .nbr_in    (cells[i+1]),
            .entry_out (cells[i])
         );
      end
   end

   sha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_word  (req_word),
      .cfg       (cfg_ff),
      .head      (cells[0]),
      .look1     (cells[1]),
      .look2     (cells[sha_pkg::LOOK2]),
      .shift_en  (shift_en),
      .tail_word (tail_word),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

### hdl/sha_cell.sv
// One table cell: holds one entry and takes its right neighbor's entry on a shift.
module sha_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  sha_pkg::entry_type nbr_in,
   output sha_pkg::entry_type entry_out
);

   sha_pkg::entry_type entry_ff;

   // payload only, no reset
   always_ff @(posedge clock) begin
      if (shift_en) begin
         entry_ff <= nbr_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

### hdl/sha_ctrl.sv
// Sequencer: scans the rotating cell row, decides, and streams the rewritten table back.
module sha_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  sha_pkg::req_type    req_word,
   input  sha_pkg::cfg_type    cfg,
   input  sha_pkg::entry_type  head,
   input  sha_pkg::entry_type  look1,
   input  sha_pkg::entry_type  look2,
   output logic                shift_en,
   output sha_pkg::entry_type  tail_word,
   output logic                busy,
   output logic                rsp_valid,
   output sha_pkg::rsp_type    rsp_word
);

   localparam logic [sha_pkg::IDX_W-1:0] LAST = sha_pkg::IDX_W'(sha_pkg::MAX_ENTRIES - 1);

   sha_pkg::phase_type                 phase_ff, phase_in;
   sha_pkg::cmd_type                   op_ff, op_in;
   sha_pkg::fit_type                   pol_ff, pol_in;
   logic [sha_pkg::SIZE_W-1:0]         rsize_ff, rsize_in;
   logic [sha_pkg::ADDR_W-1:0]         rbase_ff, rbase_in;
   logic [sha_pkg::SIZE_W-1:0]         mem_ff, mem_in;
   logic [sha_pkg::SIZE_W-1:0]         seg_ff, seg_in;
   logic [sha_pkg::IDX_W-1:0]          step_ff, step_in;
   logic                               quiet_ff, quiet_in;
   logic                               found_ff, found_in;
   logic [sha_pkg::IDX_W-1:0]          pick_ff, pick_in;
   logic [sha_pkg::SIZE_W-1:0]         psize_ff, psize_in;
   logic [sha_pkg::ADDR_W-1:0]         pbase_ff, pbase_in;
   logic                               left_ff, left_in;
   logic                               right_ff, right_in;
   logic [sha_pkg::SIZE_W-1:0]         osize_ff, osize_in;
   logic [sha_pkg::ADDR_W-1:0]         mbase_ff, mbase_in;
   logic [sha_pkg::SIZE_W-1:0]         msize_ff, msize_in;
   sha_pkg::entry_type                 prev_ff, prev_in;
   sha_pkg::entry_type                 hold_ff, hold_in;
   logic [sha_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [sha_pkg::SIZE_W-1:0]         ftot_ff, ftot_in;
   sha_pkg::status_type                stat_ff, stat_in;
   logic [sha_pkg::ADDR_W-1:0]         grant_ff, grant_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   sha_pkg::rsp_type                   rsp_word_ff, rsp_word_in;

   logic [sha_pkg::SIZE_W-1:0] cmem, cseg;
   logic [sha_pkg::CNT_W-1:0]  kcnt;
   logic                       in_row, take, split;
   logic [sha_pkg::IDX_W-1:0]  first_out;
   logic [1:0]                 skip;

   // clamp of the init registers
   always_comb begin
      cmem = (cfg.memory_size > sha_pkg::MEM_LIMIT) ? sha_pkg::MEM_LIMIT : cfg.memory_size;
      cseg = (cfg.segment_zero_size > cmem) ? cmem : cfg.segment_zero_size;
   end

   assign kcnt      = sha_pkg::CNT_W'(step_ff);
   assign in_row    = kcnt < cnt_ff;
   assign split     = psize_ff > rsize_ff;
   assign first_out = pick_ff - sha_pkg::IDX_W'(left_ff);
   assign skip      = 2'(left_ff) + 2'(right_ff);

   // fit choice for the entry at the head
   always_comb begin
      take = 1'b0;
      if (in_row && head.free && (head.size >= rsize_ff)) begin
         if (!found_ff) begin
            take = 1'b1;
         end else if (pol_ff == sha_pkg::FIT_BEST) begin
            take = head.size < psize_ff;
         end else if (pol_ff == sha_pkg::FIT_WORST) begin
            take = head.size > psize_ff;
         end
      end
   end

   // word handed to the tail cell
   always_comb begin
      tail_word = head;
      hold_in   = head;
      if (phase_ff == sha_pkg::PH_APPLY) begin
         case (op_ff)
            sha_pkg::CMD_INIT: begin
               tail_word = '0;
               if (step_ff == '0) begin
                  tail_word.size = seg_ff;
               end else if ((step_ff == sha_pkg::IDX_W'(1)) && (mem_ff > seg_ff)) begin
                  tail_word.base = seg_ff[sha_pkg::ADDR_W-1:0];
                  tail_word.size = mem_ff - seg_ff;
                  tail_word.free = 1'b1;
               end
            end
            sha_pkg::CMD_ALLOC: begin
               if (step_ff == pick_ff) begin
                  tail_word.size = rsize_ff;
                  tail_word.free = 1'b0;
                  hold_in.base   = head.base + rsize_ff[sha_pkg::ADDR_W-1:0];
                  hold_in.size   = head.size - rsize_ff;
                  hold_in.free   = 1'b1;
               end else if ((step_ff > pick_ff) && split) begin
                  tail_word = hold_ff;
               end
            end
            sha_pkg::CMD_FREE: begin
               if (step_ff == first_out) begin
                  tail_word.base = mbase_ff;
                  tail_word.size = msize_ff;
                  tail_word.free = 1'b1;
               end else if (step_ff > first_out) begin
                  case (skip)
                     2'd0:    tail_word = head;
                     2'd1:    tail_word = look1;
                     default: tail_word = look2;
                  endcase
               end
            end
            default: tail_word = head;
         endcase
      end
   end

   assign shift_en = (phase_ff == sha_pkg::PH_SCAN) || (phase_ff == sha_pkg::PH_APPLY);

   // next state and outputs
   always_comb begin
      phase_in     = phase_ff;
      op_in        = op_ff;
      pol_in       = pol_ff;
      rsize_in     = rsize_ff;
      rbase_in     = rbase_ff;
      mem_in       = mem_ff;
      seg_in       = seg_ff;
      step_in      = step_ff;
      quiet_in     = quiet_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      psize_in     = psize_ff;
      pbase_in     = pbase_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      osize_in     = osize_ff;
      mbase_in     = mbase_ff;
      msize_in     = msize_ff;
      prev_in      = prev_ff;
      cnt_in       = cnt_ff;
      ftot_in      = ftot_ff;
      stat_in      = stat_ff;
      grant_in     = grant_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      case (phase_ff)
         sha_pkg::PH_IDLE: begin
            if (start) begin
               op_in    = req_word.cmd;
               pol_in   = cfg.fit_policy;
               rsize_in = req_word.alloc_size;
               rbase_in = req_word.segment_base;
               step_in  = '0;
               quiet_in = 1'b0;
               found_in = 1'b0;
               stat_in  = sha_pkg::ST_OK;
               grant_in = '0;
               case (req_word.cmd)
                  sha_pkg::CMD_INIT: begin
                     mem_in   = cmem;
                     seg_in   = cseg;
                     cnt_in   = (cmem > cseg) ? sha_pkg::CNT_W'(2) : sha_pkg::CNT_W'(1);
                     ftot_in  = cmem - cseg;
                     phase_in = sha_pkg::PH_APPLY;
                  end
                  sha_pkg::CMD_ALLOC: phase_in = sha_pkg::PH_SCAN;
                  sha_pkg::CMD_FREE:  phase_in = sha_pkg::PH_SCAN;
                  default:            phase_in = sha_pkg::PH_DONE;
               endcase
            end
         end
         sha_pkg::PH_SCAN: begin
            prev_in = head;
            step_in = step_ff + 1'b1;
            if (op_ff == sha_pkg::CMD_ALLOC) begin
               if (take) begin
                  found_in = 1'b1;
                  pick_in  = step_ff;
                  psize_in = head.size;
                  pbase_in = head.base;
               end
            end else if (in_row && (step_ff != '0) && !head.free && !found_ff
                         && (head.base == rbase_ff)) begin
               found_in = 1'b1;
               pick_in  = step_ff;
               left_in  = (step_ff > sha_pkg::IDX_W'(1)) && prev_ff.free;
               right_in = ((kcnt + 1'b1) < cnt_ff) && look1.free;
               osize_in = head.size;
               mbase_in = ((step_ff > sha_pkg::IDX_W'(1)) && prev_ff.free) ? prev_ff.base
                                                                           : head.base;
               msize_in = head.size
                        + (((step_ff > sha_pkg::IDX_W'(1)) && prev_ff.free) ? prev_ff.size : '0)
                        + ((((kcnt + 1'b1) < cnt_ff) && look1.free) ? look1.size : '0);
            end
            if (step_ff == LAST) begin
               phase_in = sha_pkg::PH_DECIDE;
            end
         end
         sha_pkg::PH_DECIDE: begin
            step_in  = '0;
            phase_in = sha_pkg::PH_DONE;
            if (op_ff == sha_pkg::CMD_ALLOC) begin
               if (rsize_ff == '0) begin
                  stat_in = sha_pkg::ST_NO_SPACE;
               end else if (!found_ff) begin
                  stat_in = (ftot_ff >= rsize_ff) ? sha_pkg::ST_COMPACT : sha_pkg::ST_NO_SPACE;
               end else if (split && (cnt_ff >= sha_pkg::CNT_W'(sha_pkg::MAX_ENTRIES))) begin
                  stat_in = sha_pkg::ST_FULL;
               end else begin
                  grant_in = pbase_ff;
                  cnt_in   = cnt_ff + sha_pkg::CNT_W'(split);
                  ftot_in  = ftot_ff - rsize_ff;
                  phase_in = sha_pkg::PH_APPLY;
               end
            end else if (!found_ff) begin
               stat_in = sha_pkg::ST_NOT_FOUND;
            end else begin
               grant_in = mbase_ff;
               cnt_in   = cnt_ff - sha_pkg::CNT_W'(left_ff) - sha_pkg::CNT_W'(right_ff);
               ftot_in  = ftot_ff + osize_ff;
               phase_in = sha_pkg::PH_APPLY;
            end
         end
         sha_pkg::PH_APPLY: begin
            step_in = step_ff + 1'b1;
            if (step_ff == LAST) begin
               phase_in = quiet_ff ? sha_pkg::PH_IDLE : sha_pkg::PH_DONE;
            end
         end
         sha_pkg::PH_DONE: begin
            rsp_valid_in             = 1'b1;
            rsp_word_in.status       = stat_ff;
            rsp_word_in.granted_base = grant_ff;
            rsp_word_in.free_total   = ftot_ff;
            rsp_word_in.entry_count  = cnt_ff;
            phase_in                 = sha_pkg::PH_IDLE;
         end
         default: phase_in = sha_pkg::PH_IDLE;
      endcase
   end

   // control registers; reset runs a silent init pass with the reset register values
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sha_pkg::PH_APPLY;
         op_ff        <= sha_pkg::CMD_INIT;
         step_ff      <= '0;
         quiet_ff     <= 1'b1;
         found_ff     <= 1'b0;
         mem_ff       <= sha_pkg::MEM_RESET;
         seg_ff       <= sha_pkg::SEG0_RESET;
         cnt_ff       <= sha_pkg::CNT_W'(2);
         ftot_ff      <= sha_pkg::MEM_RESET - sha_pkg::SEG0_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         op_ff        <= op_in;
         step_ff      <= step_in;
         quiet_ff     <= quiet_in;
         found_ff     <= found_in;
         mem_ff       <= mem_in;
         seg_ff       <= seg_in;
         cnt_ff       <= cnt_in;
         ftot_ff      <= ftot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // operand and result payload
   always_ff @(posedge clock) begin
      pol_ff      <= pol_in;
      rsize_ff    <= rsize_in;
      rbase_ff    <= rbase_in;
      pick_ff     <= pick_in;
      psize_ff    <= psize_in;
      pbase_ff    <= pbase_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      osize_ff    <= osize_in;
      mbase_ff    <= mbase_in;
      msize_ff    <= msize_in;
      prev_ff     <= prev_in;
      hold_ff     <= hold_in;
      stat_ff     <= stat_in;
      grant_ff    <= grant_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy      = phase_ff != sha_pkg::PH_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### hdl/sha_checker.sv
// Port-level checks of the segment hole allocator, bound to the top level.
module sha_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input sha_pkg::rsp_type           rsp_word
);

   // reset starts the init pass
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   // an accepted word keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // results are single-cycle strobes
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a failed operation grants nothing
   a_err_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.status != sha_pkg::ST_OK)) |-> (rsp_word.granted_base == '0))
      else $error("error result with nonzero base");

   // a result only follows work
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without preceding work");

endmodule

bind segment_hole_allocator sha_checker u_sha_checker (.*);

### tb/segment_hole_allocator_tb.sv
// Self-checking testbench of the segment hole allocator: directed and random commands.
module segment_hole_allocator_tb;
   import sha_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_word;
   logic                rsp_valid;
   rsp_type             rsp_word;
   logic                csr_we;
   logic [CSR_W-1:0]    csr_index;
   logic [SIZE_W-1:0]   csr_wdata;

   // predictor state: hole table and register copies
   int unsigned tbl_base [MAX_ENTRIES];
   int unsigned tbl_size [MAX_ENTRIES];
   bit          tbl_free [MAX_ENTRIES];
   int unsigned tbl_cnt;
   int unsigned cfg_fit;
   int unsigned cfg_mem;
   int unsigned cfg_seg0;

   rsp_type pending_rsp_q[$];
   bit      failed;
   bit      quiet;
   int      stall_cycles;

   segment_hole_allocator u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------- predictor ----------------
   function automatic void rebuild_table();
      int unsigned mem;
      int unsigned seg0;
      mem  = (cfg_mem > (1 << ADDR_W)) ? (1 << ADDR_W) : cfg_mem;
      seg0 = (cfg_seg0 > mem) ? mem : cfg_seg0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         tbl_base[i] = 0;
         tbl_size[i] = 0;
         tbl_free[i] = 0;
      end
      tbl_size[0] = seg0;
      tbl_cnt = 1;
      if (mem > seg0) begin
         tbl_base[1] = seg0 & ((1 << ADDR_W) - 1);
         tbl_size[1] = mem - seg0;
         tbl_free[1] = 1;
         tbl_cnt = 2;
      end
   endfunction

   function automatic int unsigned free_space();
      int unsigned s;
      s = 0;
      for (int i = 0; i < tbl_cnt; i++)
         if (tbl_free[i]) s += tbl_size[i];
      return s;
   endfunction

   function automatic void drop_entry(int unsigned idx);
      for (int unsigned i = idx; i + 1 < tbl_cnt; i++) begin
         tbl_base[i] = tbl_base[i+1];
         tbl_size[i] = tbl_size[i+1];
         tbl_free[i] = tbl_free[i+1];
      end
      tbl_cnt--;
      tbl_base[tbl_cnt] = 0;
      tbl_size[tbl_cnt] = 0;
      tbl_free[tbl_cnt] = 0;
   endfunction

   function automatic status_type run_alloc(int unsigned want, output int unsigned granted);
      int unsigned pick;
      bit          found;
      pick = 0;
      found = 0;
      granted = 0;
      if (want == 0) return ST_NO_SPACE;
      for (int unsigned i = 0; i < tbl_cnt; i++) begin
         if (!tbl_free[i] || tbl_size[i] < want) continue;
         if (!found) begin
            pick = i;
            found = 1;
            if (cfg_fit != FIT_BEST && cfg_fit != FIT_WORST) break;
         end else if (cfg_fit == FIT_BEST && tbl_size[i] < tbl_size[pick]) begin
            pick = i;
         end else if (cfg_fit == FIT_WORST && tbl_size[i] > tbl_size[pick]) begin
            pick = i;
         end
      end
      if (!found) return (free_space() >= want) ? ST_COMPACT : ST_NO_SPACE;
      // split: leftover becomes a free hole right after the pick
      if (tbl_size[pick] > want) begin
         if (tbl_cnt >= MAX_ENTRIES) return ST_FULL;
         for (int unsigned i = tbl_cnt; i > pick + 1; i--) begin
            tbl_base[i] = tbl_base[i-1];
            tbl_size[i] = tbl_size[i-1];
            tbl_free[i] = tbl_free[i-1];
         end
         tbl_base[pick+1] = (tbl_base[pick] + want) & ((1 << ADDR_W) - 1);
         tbl_size[pick+1] = tbl_size[pick] - want;
         tbl_free[pick+1] = 1;
         tbl_cnt++;
      end
      tbl_size[pick] = want;
      tbl_free[pick] = 0;
      granted = tbl_base[pick];
      return ST_OK;
   endfunction

   function automatic status_type run_release(int unsigned base, output int unsigned granted);
      int unsigned idx;
      bit          found;
      idx = 0;
      found = 0;
      granted = 0;
      for (int unsigned i = 1; i < tbl_cnt; i++) begin
         if (!tbl_free[i] && tbl_base[i] == base) begin
            idx = i;
            found = 1;
            break;
         end
      end
      if (!found) return ST_NOT_FOUND;
      tbl_free[idx] = 1;
      // merge with the lower neighbor, then the upper one
      if (idx > 1 && tbl_free[idx-1]) begin
         tbl_size[idx-1] += tbl_size[idx];
         drop_entry(idx);
         idx--;
      end
      if (idx + 1 < tbl_cnt && tbl_free[idx+1]) begin
         tbl_size[idx] += tbl_size[idx+1];
         drop_entry(idx + 1);
      end
      granted = tbl_base[idx];
      return ST_OK;
   endfunction

   function automatic rsp_type predict_response(req_type w);
      rsp_type     r;
      status_type  st;
      int unsigned granted;
      st = ST_OK;
      granted = 0;
      case (w.cmd)
         CMD_INIT:  rebuild_table();
         CMD_ALLOC: st = run_alloc(w.alloc_size, granted);
         CMD_FREE:  st = run_release(w.segment_base, granted);
         default:   ;
      endcase
      if (st != ST_OK) granted = 0;
      r.status       = st;
      r.granted_base = granted[ADDR_W-1:0];
      r.free_total   = SIZE_W'(free_space());
      r.entry_count  = CNT_W'(tbl_cnt);
      return r;
   endfunction

   // ---------------- driving ----------------
   task automatic send_word(cmd_type c, int unsigned sz, int unsigned base);
      req_type w;
      bit      offer;
      w.cmd          = c;
      w.alloc_size   = SIZE_W'(sz);
      w.segment_base = ADDR_W'(base);
      req_word <= w;
      // offer the word until it is taken; idle at random unless quiet
      forever begin
         offer = quiet || ($urandom_range(99) >= 24);
         start <= offer;
         @(posedge clock);
         if (offer && !busy) break;
      end
      pending_rsp_q.push_back(predict_response(w));
   endtask

   task automatic do_alloc(int unsigned sz);
      send_word(CMD_ALLOC, sz, $urandom_range(0, (1 << ADDR_W) - 1));
   endtask

   task automatic do_free(int unsigned base);
      send_word(CMD_FREE, $urandom_range(0, (1 << SIZE_W) - 1), base);
   endtask

   task automatic do_init();
      send_word(CMD_INIT, $urandom_range(0, (1 << SIZE_W) - 1),
                $urandom_range(0, (1 << ADDR_W) - 1));
   endtask

   // lower start and let every pending word come back
   task automatic drain();
      start <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_type idx, int unsigned val);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= SIZE_W'(val);
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_FIT:  cfg_fit  = val & 3;
         CSR_MEM:  cfg_mem  = val & ((1 << SIZE_W) - 1);
         CSR_SEG0: cfg_seg0 = val & ((1 << SIZE_W) - 1);
         default:  ;
      endcase
   endtask

   task automatic set_layout(int unsigned fit, int unsigned mem, int unsigned seg0);
      write_csr(CSR_FIT, fit);
      write_csr(CSR_MEM, mem);
      write_csr(CSR_SEG0, seg0);
      do_init();
   endtask

   // ---------------- checking ----------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp_q.size() == 0) begin
            $display("%0t: unexpected word %p", $time, rsp_word);
            failed = 1;
         end else begin
            rsp_type e;
            e = pending_rsp_q.pop_front();
            if (rsp_word.status !== e.status)
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_word.status);
            if (rsp_word.granted_base !== e.granted_base)
               $display("%0t: granted_base exp %h got %h", $time, e.granted_base,
                        rsp_word.granted_base);
            if (rsp_word.free_total !== e.free_total)
               $display("%0t: free_total exp %0d got %0d", $time, e.free_total,
                        rsp_word.free_total);
            if (rsp_word.entry_count !== e.entry_count)
               $display("%0t: entry_count exp %0d got %0d", $time, e.entry_count,
                        rsp_word.entry_count);
            if (rsp_word !== e) failed = 1;
         end
      end
   end

   // watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ---------------- tests ----------------
   task automatic test_reset_defaults();
      do_alloc(0);                    // zero-size request
      do_alloc(1 << ADDR_W);          // larger than the free hole
      do_alloc(1);
      do_free(0);                     // segment zero never matches
      do_free(129);                   // base of a free hole
      do_free(128);
      do_free(128);                   // already free
      send_word(CMD_NONE, (1 << SIZE_W) - 1, (1 << ADDR_W) - 1);
      do_alloc((1 << ADDR_W) - 128);  // exact fit of the whole hole
      do_free(128);
   endtask

   task automatic test_compaction_and_fits();
      set_layout(FIT_FIRST, 1000, 100);
      do_alloc(300);
      do_alloc(300);
      do_alloc(300);                  // exact fit, no remainder
      do_free(100);
      do_free(700);
      do_alloc(400);                  // fragmented: compaction needed
      do_alloc(700);                  // beyond free total
      write_csr(CSR_FIT, FIT_BEST);
      do_free(400);                   // three-way merge
      do_alloc(200);
      do_alloc(200);                  // carved from the same remaining hole
      write_csr(CSR_FIT, FIT_WORST);
      do_alloc(50);
      write_csr(CSR_FIT, FIT_ALT);
      do_alloc(50);
   endtask

   task automatic test_init_extremes();
      set_layout(FIT_FIRST, (1 << SIZE_W) - 1, (1 << SIZE_W) - 1);  // clamped, one entry
      do_alloc(1);
      set_layout(FIT_FIRST, 1, 0);
      do_alloc(1);
      set_layout(FIT_FIRST, 0, 0);
      do_alloc(1);
   endtask

   task automatic test_table_full();
      set_layout(FIT_FIRST, 1 << ADDR_W, 0);
      for (int i = 0; i < MAX_ENTRIES - 1; i++) do_alloc(1);
      do_alloc((1 << ADDR_W) - (MAX_ENTRIES - 2));  // exact fit still allowed
      do_free(5);
      do_free(7);
      do_free(6);
   endtask

   task automatic random_ops(int n);
      int          used [$];
      int unsigned cap;
      int unsigned roll;
      for (int k = 0; k < n; k++) begin
         used.delete();
         for (int i = 1; i < tbl_cnt; i++) if (!tbl_free[i]) used.push_back(i);
         cap  = (cfg_mem > 24) ? cfg_mem / 12 : 2;
         roll = $urandom_range(99);
         if (roll < 50) begin
            do_alloc($urandom_range(1, cap));
         end else if (roll < 88 && used.size() != 0) begin
            do_free(tbl_base[used[$urandom_range(0, used.size() - 1)]]);
         end else if (roll < 92) begin
            do_alloc($urandom_range(0, (1 << SIZE_W) - 1));
         end else if (roll < 96) begin
            do_free($urandom_range(0, (1 << ADDR_W) - 1));
         end else if (roll < 98) begin
            send_word(CMD_NONE, $urandom_range(0, (1 << SIZE_W) - 1),
                      $urandom_range(0, (1 << ADDR_W) - 1));
         end else begin
            do_init();
         end
      end
   endtask

   task automatic test_random();
      quiet = 1;
      set_layout(FIT_FIRST, 4096, 64);
      random_ops(60);
      quiet = 0;
      set_layout(FIT_BEST, 1 << ADDR_W, 128);
      random_ops(110);
      set_layout(FIT_WORST, 20000, 1000);
      random_ops(110);
      set_layout(FIT_ALT, 777, 0);
      random_ops(80);
      set_layout($urandom_range(0, 3), $urandom_range(1, (1 << SIZE_W) - 1),
                 $urandom_range(0, 4096));
      random_ops(80);
   endtask

   initial begin
      failed       = 0;
      quiet        = 0;
      stall_cycles = 0;
      reset     = 1'b1;
      start     = 1'b0;
      req_word  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_FIT;
      csr_wdata = '0;
      cfg_fit   = FIT_FIRST;
      cfg_mem   = MEM_RESET;
      cfg_seg0  = SEG0_RESET;
      rebuild_table();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_compaction_and_fits();
      test_init_extremes();
      test_table_full();
      test_random();
      drain();
      repeat (2 * MAX_ENTRIES + 8) @(posedge clock);

      if (!failed && pending_rsp_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/sha_pkg.sv
hdl/sha_cell.sv
hdl/sha_ctrl.sv
hdl/segment_hole_allocator.sv
hdl/sha_checker.sv
tb/segment_hole_allocator_tb.sv
